// ----- rtl/core/ttc_pkg.sv -----
`timescale 1ns / 1ps

package ttc_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LatW   = 31;
  localparam int unsigned LonW   = 32;
  localparam int unsigned AltW   = 25;
  localparam int unsigned SatW   = 8;
  localparam int unsigned HdopW  = 16;
  localparam int unsigned TagW   = 16;
  localparam int unsigned CfgW   = 21;
  localparam int unsigned GapW   = 17;
  // signed query time and time distances
  localparam int unsigned QW     = 35;
  // interpolation unit widths
  localparam int unsigned ValW   = 32;
  localparam int unsigned NumW   = 18;
  localparam int unsigned DenW   = 18;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_TIME_OFFSET = 2'd0,
    CFG_MAX_GAP     = 2'd1,
    CFG_INTERP_EN   = 2'd2,
    CFG_INTERP_MAX  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0]        stamp;
    logic signed [LatW-1:0]  lat;
    logic signed [LonW-1:0]  lon;
    logic signed [AltW-1:0]  alt;
    logic                    alt_valid;
    logic [SatW-1:0]         sats;
    logic [HdopW-1:0]        hdop;
  } fix_t;

endpackage

// ----- rtl/core/ttc_fix_store.sv -----
`timescale 1ns / 1ps

module ttc_fix_store
  import ttc_pkg::*;
#(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  fix_t          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output fix_t          rdata_o
);

  fix_t mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/core/ttc_lerp_unit.sv -----
`timescale 1ns / 1ps

module ttc_lerp_unit
  import ttc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [ValW-1:0] a_i,
  input  logic signed [ValW-1:0] b_i,
  input  logic [NumW-1:0]        num_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [ValW-1:0] res_o
);

  localparam int unsigned DiffW = ValW + 1;
  localparam int unsigned PW    = DiffW + NumW + 1;
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned RW    = DenW + 2;
  localparam int unsigned CW    = $clog2(NW);

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_PREP, U_DIV, U_FIN} ustate_e;

  ustate_e                 state_q;
  logic signed [ValW-1:0]  a_q;
  logic signed [DiffW-1:0] diff_q;
  logic [NumW-1:0]         num_q;
  logic [DenW-1:0]         den_q;
  logic signed [PW-1:0]    prod_q;
  logic                    neg_q;
  logic [NW-1:0]           quo_q;
  logic [RW-1:0]           rem_q;
  logic [CW-1:0]           cnt_q;

  logic [PW-1:0]  mag;
  logic [RW-1:0]  rem_sh;
  logic [RW-1:0]  div2;
  logic           qbit;
  logic [DiffW-1:0] sum;

  // magnitude of the product, one restoring division step and the final signed add
  always_comb begin
    mag    = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    rem_sh = {rem_q[RW-2:0], quo_q[NW-1]};
    div2   = RW'({den_q, 1'b0});
    qbit   = (rem_sh >= div2);
    sum    = neg_q ? DiffW'(a_q) - DiffW'(quo_q) : DiffW'(a_q) + DiffW'(quo_q);
  end

  // sequencer: difference, multiply, rounded divide, final add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_o <= (state_q == U_FIN);
      case (state_q)
        U_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            diff_q  <= DiffW'(b_i) - DiffW'(a_i);
            num_q   <= num_i;
            den_q   <= den_i;
            state_q <= U_MUL;
          end
        end
        U_MUL: begin
          prod_q  <= PW'(diff_q * $signed({1'b0, num_q}));
          state_q <= U_PREP;
        end
        U_PREP: begin
          neg_q   <= prod_q[PW-1];
          quo_q   <= NW'({mag, 1'b0}) + NW'(den_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= U_DIV;
        end
        U_DIV: begin
          rem_q <= qbit ? rem_sh - div2 : rem_sh;
          quo_q <= {quo_q[NW-2:0], qbit};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(NW - 1)) begin
            state_q <= U_FIN;
          end
        end
        U_FIN: begin
          res_o   <= ValW'(sum);
          state_q <= U_IDLE;
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/timestamp_track_correlator_top.sv -----
`timescale 1ns / 1ps
// Correlates time-stamped queries with position fixes held in several tracks.
// Input channel (in_valid_i/in_ready_o) takes one command word: clear tracks,
// load a fix, start a query run, or query. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Output channel (out_valid_o/out_ready_i) gives one word per query that
// found a usable fix; queries without a match give nothing. Clear, start
// and load words are handled without leaving the idle state. A query walks
// every track's cursor through the fix memory over its single read port,
// then reads the fix to copy. Interpolation adds two fix reads and up to
// three passes of the shared multiply/divide unit.
// One word is worked on at a time; in_ready_o is high only while idle. A
// finished result sits in the output register, and the next word is taken
// while it waits; a later result waits until the receiver takes it.
// Reset empties all tracks, zeroes the cursors and loads register defaults
// (offset 0, max gap 30, interpolation off, interpolation distance 600).
// The fix memory is not cleared; only entries below a track's fill are read.

module timestamp_track_correlator_top
  import ttc_pkg::*;
#(
  parameter int unsigned NUM_TRACKS      = 8,
  parameter int unsigned FIXES_PER_TRACK = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              cmd_i,
  input  logic [2:0]              track_i,
  input  logic [TimeW-1:0]        stamp_i,
  input  logic signed [LatW-1:0]  latitude_i,
  input  logic signed [LonW-1:0]  longitude_i,
  input  logic signed [AltW-1:0]  altitude_i,
  input  logic                    altitude_valid_i,
  input  logic [SatW-1:0]         sat_count_i,
  input  logic [HdopW-1:0]        precision_i,
  input  logic [TagW-1:0]         query_tag_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [TagW-1:0]         result_tag_o,
  output logic signed [LatW-1:0]  out_latitude_o,
  output logic signed [LonW-1:0]  out_longitude_o,
  output logic signed [AltW-1:0]  out_altitude_o,
  output logic                    out_altitude_valid_o,
  output logic [SatW-1:0]         out_sat_count_o,
  output logic [HdopW-1:0]        out_precision_o,
  output logic                    was_interpolated_o
);

  localparam int unsigned Depth = NUM_TRACKS * FIXES_PER_TRACK;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int unsigned FW    = $clog2(FIXES_PER_TRACK + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRK_RD, ST_TRK_CHK, ST_BEF_RD, ST_BEF_CHK, ST_NEXT,
    ST_DECIDE, ST_CPY_WAIT, ST_IB_RD, ST_IA_RD, ST_IA_WAIT,
    ST_L_GO, ST_L_WAIT, ST_OUT
  } state_e;

  typedef enum logic [1:0] {F_LAT, F_LON, F_ALT} field_e;

  // configuration registers
  logic signed [CfgW-1:0] offset_q;
  logic [GapW-1:0]        max_gap_q;
  logic                   interp_en_q;
  logic [GapW-1:0]        interp_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      max_gap_q    <= GapW'(30);
      interp_en_q  <= 1'b0;
      interp_max_q <= GapW'(600);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_OFFSET: offset_q     <= cfg_data_i;
        CFG_MAX_GAP:     max_gap_q    <= cfg_data_i[GapW-1:0];
        CFG_INTERP_EN:   interp_en_q  <= cfg_data_i[0];
        CFG_INTERP_MAX:  interp_max_q <= cfg_data_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  state_e                 state_q;
  field_e                 fld_q;
  logic [FW-1:0]          fill_q [NUM_TRACKS];
  logic [FW-1:0]          cursor_q [NUM_TRACKS];
  logic [TW-1:0]          t_q;
  logic [FW-1:0]          cur_q;
  logic signed [QW-1:0]   q_q;
  logic [TagW-1:0]        tag_q;
  logic                   hb_q, ha_q;
  logic [TimeW-1:0]       tb_q, ta_q;
  logic [AW-1:0]          ib_q, ia_q;
  fix_t                   fb_q, fa_q;
  logic signed [LatW-1:0] res_lat_q;
  logic signed [LonW-1:0] res_lon_q;
  logic signed [AltW-1:0] res_alt_q;
  logic                   res_av_q;
  logic [SatW-1:0]        res_sat_q;
  logic [HdopW-1:0]       res_hdop_q;
  logic                   res_interp_q;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  fix_t          mem_wdata, mem_rdata;

  // interpolation unit ports
  logic                   lu_start, lu_done;
  logic signed [ValW-1:0] lu_a, lu_b, lu_res;

  logic                   accept;
  logic [TW-1:0]          in_trk;
  logic                   trk_ok;
  logic [TW-1:0]          t_nx;
  logic [AW-1:0]          base;
  logic [AW-1:0]          cur_addr;
  logic signed [QW-1:0]   rd_time;
  logic signed [QW-1:0]   db, da;
  logic                   ub, ua, ui;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_trk     = TW'(track_i);
  assign trk_ok     = (32'(track_i) < NUM_TRACKS);
  assign t_nx       = t_q + 1'b1;

  // address of the fix at the working cursor
  assign base     = AW'(32'(t_q) * 32'(FIXES_PER_TRACK));
  assign cur_addr = base + AW'(cur_q);
  assign rd_time  = $signed(QW'(mem_rdata.stamp));

  // distances and match tests of the chosen candidates
  assign db = q_q - $signed(QW'(tb_q));
  assign da = $signed(QW'(ta_q)) - q_q;
  assign ub = hb_q && (db <= $signed(QW'(max_gap_q)));
  assign ua = ha_q && (da <= $signed(QW'(max_gap_q)));
  assign ui = interp_en_q && hb_q && ha_q &&
              (db <= $signed(QW'(interp_max_q))) &&
              (da <= $signed(QW'(interp_max_q)));

  // load path: write at the fill position of the addressed track
  always_comb begin
    mem_we    = accept && (cmd_e'(cmd_i) == CMD_LOAD) && trk_ok &&
                (fill_q[in_trk] < FW'(FIXES_PER_TRACK));
    mem_waddr = AW'(32'(in_trk) * 32'(FIXES_PER_TRACK)) + AW'(fill_q[in_trk]);
    mem_wdata = '{stamp: stamp_i, lat: latitude_i, lon: longitude_i,
                  alt: altitude_i, alt_valid: altitude_valid_i,
                  sats: sat_count_i, hdop: precision_i};
  end

  // read port address per state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cur_addr;
    case (state_q)
      ST_TRK_RD: mem_re = (cur_q < fill_q[t_q]);
      ST_BEF_RD: begin
        mem_re    = (cur_q != '0);
        mem_raddr = cur_addr - 1'b1;
      end
      ST_DECIDE: begin
        mem_re    = 1'b1;
        mem_raddr = (ub && ua) ? ((db < da) ? ib_q : ia_q) : (ua ? ia_q : ib_q);
      end
      ST_IB_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ib_q;
      end
      ST_IA_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ia_q;
      end
      default: ;
    endcase
  end

  // operands for the interpolation unit
  always_comb begin
    case (fld_q)
      F_LAT: begin
        lu_a = ValW'(fb_q.lat);
        lu_b = ValW'(fa_q.lat);
      end
      F_LON: begin
        lu_a = ValW'(fb_q.lon);
        lu_b = ValW'(fa_q.lon);
      end
      default: begin
        lu_a = ValW'(fb_q.alt);
        lu_b = ValW'(fa_q.alt);
      end
    endcase
  end

  assign lu_start = (state_q == ST_L_GO);

  ttc_lerp_unit u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lu_start),
    .a_i     (lu_a),
    .b_i     (lu_b),
    .num_i   (NumW'(db)),
    .den_i   (DenW'(db + da)),
    .done_o  (lu_done),
    .res_o   (lu_res)
  );

  ttc_fix_store #(
    .Depth (Depth),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // query sequencer, track state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fld_q       <= F_LAT;
      out_valid_o <= 1'b0;
      t_q         <= '0;
      cur_q       <= '0;
      hb_q        <= 1'b0;
      ha_q        <= 1'b0;
      for (int i = 0; i < NUM_TRACKS; i++) begin
        fill_q[i]   <= '0;
        cursor_q[i] <= '0;
      end
    end else begin
      // the output state handles the valid flag itself
      if (out_valid_o && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_e'(cmd_i))
              CMD_CLEAR: begin
                for (int i = 0; i < NUM_TRACKS; i++) begin
                  fill_q[i]   <= '0;
                  cursor_q[i] <= '0;
                end
              end
              CMD_RUN: begin
                for (int i = 0; i < NUM_TRACKS; i++) begin
                  cursor_q[i] <= '0;
                end
              end
              CMD_LOAD: begin
                if (mem_we) begin
                  fill_q[in_trk] <= fill_q[in_trk] + 1'b1;
                end
              end
              default: begin
                q_q     <= $signed(QW'(stamp_i)) - QW'(offset_q);
                tag_q   <= query_tag_i;
                t_q     <= '0;
                cur_q   <= cursor_q[0];
                hb_q    <= 1'b0;
                ha_q    <= 1'b0;
                state_q <= ST_TRK_RD;
              end
            endcase
          end
        end
        // advance the cursor past fixes older than the query
        ST_TRK_RD: begin
          state_q <= (cur_q < fill_q[t_q]) ? ST_TRK_CHK : ST_BEF_RD;
        end
        ST_TRK_CHK: begin
          if (rd_time < q_q) begin
            cur_q   <= cur_q + 1'b1;
            state_q <= ST_TRK_RD;
          end else begin
            if (!ha_q || (mem_rdata.stamp < ta_q)) begin
              ha_q <= 1'b1;
              ta_q <= mem_rdata.stamp;
              ia_q <= cur_addr;
            end
            state_q <= ST_BEF_RD;
          end
        end
        // fix just behind the cursor
        ST_BEF_RD: begin
          state_q <= (cur_q != '0) ? ST_BEF_CHK : ST_NEXT;
        end
        ST_BEF_CHK: begin
          if ((rd_time < q_q) && (!hb_q || (mem_rdata.stamp > tb_q))) begin
            hb_q <= 1'b1;
            tb_q <= mem_rdata.stamp;
            ib_q <= cur_addr - 1'b1;
          end
          state_q <= ST_NEXT;
        end
        ST_NEXT: begin
          cursor_q[t_q] <= cur_q;
          if (32'(t_q) == NUM_TRACKS - 1) begin
            state_q <= ST_DECIDE;
          end else begin
            t_q     <= t_nx;
            cur_q   <= cursor_q[t_nx];
            state_q <= ST_TRK_RD;
          end
        end
        // pick copy, interpolation or no result
        ST_DECIDE: begin
          if (ub || ua) begin
            state_q <= ST_CPY_WAIT;
          end else if (ui) begin
            state_q <= ST_IB_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_CPY_WAIT: begin
          res_lat_q    <= mem_rdata.lat;
          res_lon_q    <= mem_rdata.lon;
          res_alt_q    <= mem_rdata.alt_valid ? mem_rdata.alt : '0;
          res_av_q     <= mem_rdata.alt_valid;
          res_sat_q    <= mem_rdata.sats;
          res_hdop_q   <= mem_rdata.hdop;
          res_interp_q <= 1'b0;
          state_q      <= ST_OUT;
        end
        ST_IB_RD: begin
          state_q <= ST_IA_RD;
        end
        ST_IA_RD: begin
          fb_q    <= mem_rdata;
          state_q <= ST_IA_WAIT;
        end
        ST_IA_WAIT: begin
          fa_q         <= mem_rdata;
          fld_q        <= F_LAT;
          res_av_q     <= fb_q.alt_valid && mem_rdata.alt_valid;
          res_alt_q    <= '0;
          res_sat_q    <= '1;
          res_hdop_q   <= '1;
          res_interp_q <= 1'b1;
          state_q      <= ST_L_GO;
        end
        ST_L_GO: begin
          state_q <= ST_L_WAIT;
        end
        ST_L_WAIT: begin
          if (lu_done) begin
            case (fld_q)
              F_LAT: begin
                res_lat_q <= LatW'(lu_res);
                fld_q     <= F_LON;
                state_q   <= ST_L_GO;
              end
              F_LON: begin
                res_lon_q <= LonW'(lu_res);
                if (res_av_q) begin
                  fld_q   <= F_ALT;
                  state_q <= ST_L_GO;
                end else begin
                  state_q <= ST_OUT;
                end
              end
              default: begin
                res_alt_q <= AltW'(lu_res);
                state_q   <= ST_OUT;
              end
            endcase
          end
        end
        // hand the word to the output register once it is free
        ST_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o          <= 1'b1;
            result_tag_o         <= tag_q;
            out_latitude_o       <= res_lat_q;
            out_longitude_o      <= res_lon_q;
            out_altitude_o       <= res_alt_q;
            out_altitude_valid_o <= res_av_q;
            out_sat_count_o      <= res_sat_q;
            out_precision_o      <= res_hdop_q;
            was_interpolated_o   <= res_interp_q;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/timestamp_track_correlator_top_tb.sv -----
`timescale 1ns / 1ps

module timestamp_track_correlator_top_tb;
  import ttc_pkg::*;

  localparam int NTRK = 8;
  localparam int NFIX = 1024;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] cmd_i;
  logic [2:0] track_i;
  logic [TimeW-1:0] stamp_i;
  logic signed [LatW-1:0] latitude_i;
  logic signed [LonW-1:0] longitude_i;
  logic signed [AltW-1:0] altitude_i;
  logic altitude_valid_i;
  logic [SatW-1:0] sat_count_i;
  logic [HdopW-1:0] precision_i;
  logic [TagW-1:0] query_tag_i;
  logic out_valid_o, out_ready_i;
  logic [TagW-1:0] result_tag_o;
  logic signed [LatW-1:0] out_latitude_o;
  logic signed [LonW-1:0] out_longitude_o;
  logic signed [AltW-1:0] out_altitude_o;
  logic out_altitude_valid_o;
  logic [SatW-1:0] out_sat_count_o;
  logic [HdopW-1:0] out_precision_o;
  logic was_interpolated_o;

  timestamp_track_correlator_top dut (.*);

  // one input word
  typedef struct {
    cmd_e cmd;
    logic [2:0] trk;
    logic [31:0] stamp;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [24:0] alt;
    logic av;
    logic [7:0] sats;
    logic [15:0] hdop;
    logic [15:0] tag;
  } word_t;

  // one match result
  typedef struct packed {
    logic [15:0] tag;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [24:0] alt;
    logic av;
    logic [7:0] sats;
    logic [15:0] hdop;
    logic interp;
  } match_t;

  // track store mirror
  fix_t fixes [NTRK][NFIX];
  int fill [NTRK];
  int cursor [NTRK];
  longint offset_s;
  longint gap_s;
  bit interp_on;
  longint interp_dist_s;

  match_t pending_q[$];
  int errors;
  longint cycles = 0;
  bit stim_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // rounded linear blend, ties away from zero
  function automatic longint blend(longint a, longint b, longint num, longint den);
    longint p, mag, qv;
    p = (b - a) * num;
    mag = (p < 0) ? -p : p;
    qv = (2 * mag + den) / (2 * den);
    return (p < 0) ? a - qv : a + qv;
  endfunction

  // track/match predictor; returns 1 when a result is expected
  function automatic bit correlate(word_t w, output match_t m);
    longint qt, tb, ta, db, da, ft, den;
    bit hb, ha, ub, ua, useb;
    int bt, bi, at, ai, c;
    hb = 0; ha = 0; tb = 0; ta = 0; bt = 0; bi = 0; at = 0; ai = 0;
    m = '{default: '0};
    case (w.cmd)
      CMD_CLEAR, CMD_RUN: begin
        for (int t = 0; t < NTRK; t++) begin
          if (w.cmd == CMD_CLEAR) fill[t] = 0;
          cursor[t] = 0;
        end
        return 0;
      end
      CMD_LOAD: begin
        if (fill[w.trk] < NFIX) begin
          fixes[w.trk][fill[w.trk]] = '{w.stamp, w.lat, w.lon, w.alt, w.av, w.sats, w.hdop};
          fill[w.trk]++;
        end
        return 0;
      end
      default: ;
    endcase
    qt = longint'(w.stamp) - offset_s;
    for (int t = 0; t < NTRK; t++) begin
      c = cursor[t];
      while (c < fill[t] && longint'(fixes[t][c].stamp) < qt) c++;
      cursor[t] = c;
      if (c > 0) begin
        ft = longint'(fixes[t][c-1].stamp);
        if (ft < qt && (!hb || ft > tb)) begin
          hb = 1; tb = ft; bt = t; bi = c - 1;
        end
      end
      if (c < fill[t]) begin
        ft = longint'(fixes[t][c].stamp);
        if (!ha || ft < ta) begin
          ha = 1; ta = ft; at = t; ai = c;
        end
      end
    end
    db = qt - tb;
    da = ta - qt;
    ub = hb && db <= gap_s;
    ua = ha && da <= gap_s;
    m.tag = w.tag;
    if (ub || ua) begin
      useb = (ub && ua) ? (db < da) : !ua;
      begin
        fix_t f;
        f = useb ? fixes[bt][bi] : fixes[at][ai];
        m.lat = f.lat; m.lon = f.lon; m.av = f.alt_valid;
        m.alt = f.alt_valid ? f.alt : '0;
        m.sats = f.sats; m.hdop = f.hdop; m.interp = 0;
      end
      return 1;
    end
    if (interp_on && hb && ha && db <= interp_dist_s && da <= interp_dist_s) begin
      den = ta - tb;
      m.lat = blend(fixes[bt][bi].lat, fixes[at][ai].lat, db, den);
      m.lon = blend(fixes[bt][bi].lon, fixes[at][ai].lon, db, den);
      m.av = fixes[bt][bi].alt_valid && fixes[at][ai].alt_valid;
      m.alt = m.av ? blend(fixes[bt][bi].alt, fixes[at][ai].alt, db, den) : '0;
      m.sats = 8'hFF; m.hdop = 16'hFFFF; m.interp = 1;
      return 1;
    end
    return 0;
  endfunction

  // mostly short gaps, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic idle_wait(int n);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val[CfgW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_TIME_OFFSET: offset_s = longint'($signed(val[20:0]));
      CFG_MAX_GAP:     gap_s = val[16:0];
      CFG_INTERP_EN:   interp_on = val[0];
      default:         interp_dist_s = val[16:0];
    endcase
  endtask

  // send one word and record the expected match
  task automatic send_word(word_t w);
    match_t m;
    idle_wait(idle_len());
    in_valid_i = 1'b1;
    cmd_i = w.cmd; track_i = w.trk; stamp_i = w.stamp; latitude_i = w.lat;
    longitude_i = w.lon; altitude_i = w.alt; altitude_valid_i = w.av;
    sat_count_i = w.sats; precision_i = w.hdop; query_tag_i = w.tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (correlate(w, m)) pending_q.push_back(m);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // wait until every expected result is taken, then past the longest query walk
  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk_i);
    idle_wait(25000);
  endtask

  function automatic word_t rnd_fix(int trk, logic [31:0] st);
    word_t w;
    w.cmd = CMD_LOAD; w.trk = trk; w.stamp = st;
    w.lat = $signed($urandom_range(0, 1800000000)) - 900000000;
    w.lon = $signed($urandom_range(0, 2147483647)) - 1073741824;
    if ($urandom_range(0, 9) == 0) w.lon = $urandom_range(0, 1) ? 1800000000 : -1800000000;
    w.alt = $signed($urandom_range(0, 11000000)) - 1000000;
    w.av = $urandom_range(0, 3) != 0;
    w.sats = $urandom; w.hdop = $urandom; w.tag = $urandom;
    return w;
  endfunction

  function automatic word_t mk(cmd_e c, int trk, logic [31:0] st, logic [15:0] tag);
    word_t w;
    w = '{cmd: CMD_CLEAR, default: '0};
    w.cmd = c; w.trk = trk; w.stamp = st; w.tag = tag;
    return w;
  endfunction

  // output side: random stall, compare with oldest expectation
  initial begin
    match_t e;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(0, 9) < 7) || stim_done;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $display("%0t: result with no expectation, tag %0d", $time, result_tag_o);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (result_tag_o !== e.tag || out_latitude_o !== e.lat ||
              out_longitude_o !== e.lon || out_altitude_o !== e.alt ||
              out_altitude_valid_o !== e.av || out_sat_count_o !== e.sats ||
              out_precision_o !== e.hdop || was_interpolated_o !== e.interp) begin
            $display("%0t: expected tag %0d lat %0d lon %0d alt %0d av %0b sat %0d hdop %0d ip %0b",
                     $time, e.tag, e.lat, e.lon, e.alt, e.av, e.sats, e.hdop, e.interp);
            $display("%0t: actual   tag %0d lat %0d lon %0d alt %0d av %0b sat %0d hdop %0d ip %0b",
                     $time, result_tag_o, out_latitude_o, out_longitude_o, out_altitude_o,
                     out_altitude_valid_o, out_sat_count_o, out_precision_o,
                     was_interpolated_o);
            errors++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    word_t dir [$];
    match_t known [$];
    word_t w;
    int n_items, ntr, nf, nq;
    logic [31:0] t0, st;
    errors = 0; stim_done = 0;
    rst_ni = 1'b0; cfg_we_i = 0; cfg_idx_i = CFG_TIME_OFFSET; cfg_data_i = '0;
    in_valid_i = 0; cmd_i = CMD_CLEAR; track_i = 0; stamp_i = 0; latitude_i = 0;
    longitude_i = 0; altitude_i = 0; altitude_valid_i = 0; sat_count_i = 0;
    precision_i = 0; query_tag_i = 0;
    offset_s = 0; gap_s = 30; interp_on = 0; interp_dist_s = 600;
    foreach (fill[t]) begin fill[t] = 0; cursor[t] = 0; end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: extremes, all commands, track edge cases
    w = mk(CMD_QUERY, 0, 32'd100, 16'd1); dir.push_back(w);        // empty tracks
    w = mk(CMD_LOAD, 0, 32'd100, 0);
    w.lat = 900000000; w.lon = 1800000000; w.alt = 10000000; w.av = 1;
    w.sats = 8'hFF; w.hdop = 16'hFFFF; dir.push_back(w);
    w = mk(CMD_LOAD, 7, 32'hFFFF_FFFF, 0);
    w.lat = -900000000; w.lon = -1800000000; w.alt = -1000000; w.av = 0;
    dir.push_back(w);
    w = mk(CMD_LOAD, 3, 32'd0, 0); w.lat = 5; w.av = 1; w.alt = 7; dir.push_back(w);
    w = mk(CMD_LOAD, 1, 32'd100, 0); w.lat = 11; dir.push_back(w); // equal time, lower track wins
    w = mk(CMD_LOAD, 2, 32'd90, 0); w.lat = 3; dir.push_back(w);  // unsorted after later ones
    w = mk(CMD_LOAD, 2, 32'd50, 0); w.lat = 4; dir.push_back(w);
    dir.push_back(mk(CMD_QUERY, 0, 32'd100, 16'd2));
    dir.push_back(mk(CMD_QUERY, 0, 32'd95, 16'd3));               // behind the cursor
    dir.push_back(mk(CMD_QUERY, 0, 32'd0, 16'd4));
    dir.push_back(mk(CMD_RUN, 0, 0, 0));
    dir.push_back(mk(CMD_QUERY, 0, 32'd0, 16'd5));
    dir.push_back(mk(CMD_QUERY, 0, 32'd1, 16'd6));
    dir.push_back(mk(CMD_QUERY, 0, 32'hFFFF_FFFF, 16'hFFFF));
    dir.push_back(mk(CMD_QUERY, 0, 32'hFFFF_FFF0, 16'd7));
    dir.push_back(mk(CMD_CLEAR, 0, 0, 0));
    dir.push_back(mk(CMD_QUERY, 0, 32'd100, 16'd8));              // cleared
    // expected typed in: first word after reset finds nothing, tag 2 copies extreme fix
    known.push_back('{16'd2, 31'sd900000000, 32'sd1800000000, 25'sd10000000, 1'b1,
                      8'hFF, 16'hFFFF, 1'b0});
    foreach (dir[i]) begin
      if (dir[i].tag == 16'd2) begin
        match_t m;
        bit hit;
        hit = correlate(dir[i], m);
        if (!hit || m !== known[0]) begin
          $display("%0t: table row tag 2 predictor disagrees with typed value", $time);
          errors++;
        end
        pending_q.push_back(known[0]);
        // drive without re-predicting
        idle_wait(idle_len());
        in_valid_i = 1'b1; cmd_i = dir[i].cmd; stamp_i = dir[i].stamp;
        query_tag_i = dir[i].tag; track_i = dir[i].trk;
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end else begin
        send_word(dir[i]);
      end
    end
    drain();

    // register sweep, extremes included
    write_reg(CFG_TIME_OFFSET, -604800);
    write_reg(CFG_MAX_GAP, 0);
    write_reg(CFG_INTERP_EN, 1);
    write_reg(CFG_INTERP_MAX, 86400);

    // random sessions: load fixes on random tracks, then mostly time-ordered query runs
    // the full-track pass below adds about NFIX more words
    n_items = 0;
    for (int s = 0; n_items < 1300 - NFIX - 40; s++) begin
      if (s % 6 == 5) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_reg(CFG_TIME_OFFSET, $urandom_range(0, 1) ? 604800 : $urandom_range(0, 200) - 100);
          1: write_reg(CFG_MAX_GAP, $urandom_range(0, 2) == 0 ? 86400 : $urandom_range(0, 60));
          2: write_reg(CFG_INTERP_EN, $urandom_range(0, 3) != 0);
          default: write_reg(CFG_INTERP_MAX, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(20, 900));
        endcase
      end
      send_word(mk(CMD_CLEAR, 0, 0, 0));
      t0 = $urandom_range(0, 2) == 0 ? 32'hFFFF_0000 : $urandom_range(1000000, 2000000);
      ntr = $urandom_range(1, 4);
      for (int t = 0; t < ntr; t++) begin
        st = t0 + $urandom_range(0, 50);
        nf = $urandom_range(2, 10);
        for (int k = 0; k < nf; k++) begin
          w = rnd_fix($urandom_range(0, 7), st);
          if ($urandom_range(0, 15) == 0) w.stamp = $urandom;  // unsorted noise
          send_word(w); n_items++;
          st = st + $urandom_range(0, 80);
        end
      end
      for (int r = 0; r < 2; r++) begin
        send_word(mk(CMD_RUN, 0, 0, 0));
        st = t0 + offset_s - 20;
        nq = $urandom_range(3, 12);
        for (int k = 0; k < nq; k++) begin
          st = st + ($urandom_range(0, 9) == 0 ? -$urandom_range(0, 40) : $urandom_range(0, 60));
          if ($urandom_range(0, 30) == 0) st = $urandom;
          send_word(mk(CMD_QUERY, 0, st, $urandom)); n_items++;
        end
      end
      if (s == 3) drain();  // sender pauses until all results are in
    end

    // fill one track to capacity, then overflow it
    send_word(mk(CMD_CLEAR, 0, 0, 0));
    for (int k = 0; k < NFIX + 3; k++) send_word(rnd_fix(5, 32'd1000 + 2 * k));
    write_reg(CFG_MAX_GAP, 1);
    send_word(mk(CMD_RUN, 0, 0, 0));
    send_word(mk(CMD_QUERY, 0, 32'd1000 + 2 * NFIX + 2 + offset_s, 16'hABCD));
    send_word(mk(CMD_QUERY, 0, 32'd1000 + 2 * NFIX - 2 + offset_s, 16'hABCE));

    stim_done = 1;
    while (pending_q.size() != 0) @(negedge clk_i);
    idle_wait(200);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ttc_pkg.sv
rtl/core/ttc_fix_store.sv
rtl/core/ttc_lerp_unit.sv
rtl/core/timestamp_track_correlator_top.sv
dv/timestamp_track_correlator_top_tb.sv
